FILE: design/color_blindness_color_transform_defines.svh
// Assertion helpers shared by the color transform RTL.
`ifndef COLOR_BLINDNESS_COLOR_TRANSFORM_DEFINES_SVH
`define COLOR_BLINDNESS_COLOR_TRANSFORM_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define CBCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("color transform check failed");

// Clocked check that also holds during reset.
`define CBCT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("color transform check failed");

`endif

FILE: design/cbct_pkg.sv
package cbct_pkg;

  localparam int FracBitsDef = 16;
  localparam int NumRows     = 8;
  localparam longint CoefDen = 64'sd100000000;

  // Weights in units of 1e-8: two selector rows, first matrix, second matrix.
  localparam longint CoefDec [NumRows][3] = '{
    '{     999000,   6647390,   73170000 },
    '{   15338400,  31662400,    5713400 },
    '{   42633100,  87510200,    8012710 },
    '{   28110000,  57119500,   -3926270 },
    '{   -1770520,   2700840,  100247000 },
    '{   75810000, 145387000, -148060000 },
    '{   11853200,  28759500,   72550100 },
    '{    -746579,   4487110,   95430300 }
  };

  typedef struct packed {
    logic [7:0] entry_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } cbct_req_t;

  typedef struct packed {
    logic [7:0] entry_index_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       first_matrix_used;
  } cbct_rsp_t;

  // Scale a weight by 2^frac, rounding ties away from zero.
  function automatic longint scaled_coef(int row, int col, int frac);
    longint c;
    longint mag;
    longint s;
    c   = CoefDec[row][col];
    mag = (c < 0) ? -c : c;
    s   = (mag * (64'sd1 <<< frac) + CoefDen / 2) / CoefDen;
    return (c < 0) ? -s : s;
  endfunction

endpackage

FILE: design/color_blindness_color_transform.sv
// Channel   Direction  Handshake              Payload
// request   in         start_i, busy_o        req_i  (cbct_pkg::cbct_req_t)
// result    out        done_o strobe          result_o (cbct_pkg::cbct_rsp_t)
//
// Takes one request every cycle; busy_o stays low.
// The pipeline registers the products, then the row sums, then the selected and clamped result.
// Reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall, so each result shows for exactly one cycle.
`include "color_blindness_color_transform_defines.svh"

module color_blindness_color_transform #(
  parameter int FracBits = cbct_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  cbct_pkg::cbct_req_t req_i,
  output logic                done_o,
  output cbct_pkg::cbct_rsp_t result_o
);

  localparam int SumW = FracBits + 13;
  localparam int QW   = SumW - FracBits;

  logic signed [SumW-1:0] row_sum [cbct_pkg::NumRows];

  for (genvar r = 0; r < cbct_pkg::NumRows; r++) begin : g_row
    cbct_dot3 #(
      .FracBits (FracBits),
      .RowIdx   (r),
      .AddHalf  (r >= 2)
    ) u_dot3 (
      .clk_i   (clk_i),
      .red_i   (req_i.red_in),
      .green_i (req_i.green_in),
      .blue_i  (req_i.blue_in),
      .sum_o   (row_sum[r])
    );
  end

  logic [2:0] vld_d, vld_q;
  logic [7:0] idx1_q, idx2_q;
  cbct_pkg::cbct_rsp_t rsp_d, rsp_q;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[1:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= req_i.entry_index;
    idx2_q <= idx1_q;
    rsp_q  <= rsp_d;
  end

  logic                   first;
  logic signed [SumW-1:0] pick [3];
  logic [QW-1:0]          quo  [3];
  logic [7:0]             chan [3];

  always_comb begin
    first = row_sum[0] < row_sum[1];
    for (int c = 0; c < 3; c++) begin
      pick[c] = first ? row_sum[2 + c] : row_sum[5 + c];
      quo[c]  = pick[c][SumW-1:FracBits];
      // Clamp: negative goes to zero, anything past 255 saturates.
      if (pick[c][SumW-1]) begin
        chan[c] = 8'd0;
      end else if (quo[c] > QW'(255)) begin
        chan[c] = 8'd255;
      end else begin
        chan[c] = quo[c][7:0];
      end
    end
    rsp_d.entry_index_out   = idx2_q;
    rsp_d.red_out           = chan[0];
    rsp_d.green_out         = chan[1];
    rsp_d.blue_out          = chan[2];
    rsp_d.first_matrix_used = first;
  end

  assign done_o   = vld_q[2];
  assign result_o = rsp_q;

  `CBCT_ASSERT(a_latency, done_o |-> $past(start_i, 3))
  `CBCT_ASSERT(a_index_pass, done_o |-> result_o.entry_index_out == $past(req_i.entry_index, 3))
  `CBCT_ASSERT_ALWAYS(a_no_done_in_reset, !rst_ni |-> !done_o)

endmodule

FILE: design/cbct_dot3.sv
module cbct_dot3 #(
  parameter int FracBits = cbct_pkg::FracBitsDef,
  parameter int RowIdx   = 0,
  parameter bit AddHalf  = 1'b0,
  localparam int SumW    = FracBits + 13
) (
  input  logic                   clk_i,
  input  logic [7:0]             red_i,
  input  logic [7:0]             green_i,
  input  logic [7:0]             blue_i,
  output logic signed [SumW-1:0] sum_o
);

  localparam int CoefW = FracBits + 2;
  localparam int ProdW = CoefW + 9;

  localparam logic signed [CoefW-1:0] CoefR =
    CoefW'(cbct_pkg::scaled_coef(RowIdx, 0, FracBits));
  localparam logic signed [CoefW-1:0] CoefG =
    CoefW'(cbct_pkg::scaled_coef(RowIdx, 1, FracBits));
  localparam logic signed [CoefW-1:0] CoefB =
    CoefW'(cbct_pkg::scaled_coef(RowIdx, 2, FracBits));
  localparam logic signed [SumW-1:0] Bias =
    AddHalf ? (SumW'(1) <<< (FracBits - 1)) : '0;

  logic signed [ProdW-1:0] prod_r_d, prod_g_d, prod_b_d;
  logic signed [ProdW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic signed [SumW-1:0]  sum_d, sum_q;

  always_comb begin
    prod_r_d = CoefR * $signed({1'b0, red_i});
    prod_g_d = CoefG * $signed({1'b0, green_i});
    prod_b_d = CoefB * $signed({1'b0, blue_i});
  end

  always_ff @(posedge clk_i) begin
    prod_r_q <= prod_r_d;
    prod_g_q <= prod_g_d;
    prod_b_q <= prod_b_d;
  end

  // Fold the rounding offset in here so the last stage only selects and clamps.
  assign sum_d = SumW'(prod_r_q) + SumW'(prod_g_q) + SumW'(prod_b_q) + Bias;

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule
